// ===== rtl/vrc4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc4_pkg: shared types and constants
// Request and result structs, controller commands and decode codes.
// ----------------------------------------------------------------------------
package vrc4_pkg;

	localparam int unsigned PRESCALE_PERIOD = 341;
	localparam int unsigned PRESCALE_STEP   = 3;
	localparam int unsigned PRESC_W         = $clog2(PRESCALE_PERIOD + PRESCALE_STEP + 1);
	localparam int unsigned CHR_SLOTS       = 8;
	localparam int unsigned PRG_MAX_BANKS   = 512;

	localparam logic [3:0] GRP_PRG0   = 4'h8;
	localparam logic [3:0] GRP_MIRSW  = 4'h9;
	localparam logic [3:0] GRP_PRG1   = 4'hA;
	localparam logic [3:0] GRP_CHR_LO = 4'hB;
	localparam logic [3:0] GRP_CHR_HI = 4'hE;
	localparam logic [3:0] GRP_IRQ    = 4'hF;

	localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
	localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
	localparam logic [1:0] IRQ_CTRL     = 2'd2;
	localparam logic [1:0] IRQ_ACK      = 2'd3;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_PRG    = 2'd1;
	localparam logic [1:0] EV_CHR    = 2'd2;
	localparam logic [1:0] EV_MIRROR = 2'd3;

	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [1:0] CFG_FOUR_SCR  = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] address;
		logic [7:0]  data;
	} req_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [2:0] slot;
		logic [8:0] bank;
		logic [1:0] mirror_mode;
		logic       irq_line;
		logic       last;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_START,
		ST_MOD,
		ST_PRESC,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_PRG,
		CLS_CHR,
		CLS_MIR,
		CLS_TICK
	} item_cls_t;

	typedef struct packed {
		logic       load_in;
		logic       apply;
		logic       div_start;
		logic       div_step;
		logic       presc_step;
		logic       load_out;
		logic       last;
		logic [1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		item_cls_t cls;
		logic      pres_ge;
	} dp_status_t;

endpackage

// ===== rtl/vrc4_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc4_ctl: sequencer
// Steps each request through update, remainder or prescaler where needed, and result emission.
// ----------------------------------------------------------------------------
module vrc4_ctl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	input  vrc4_pkg::dp_status_t  status,
	output vrc4_pkg::dp_cmd_t     cmd
);

	vrc4_pkg::ctl_state_t state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [2:0] step_q, step_d;
	logic       res_valid_q;
	logic       out_free;
	logic       is_last;

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign is_last   = (status.cls != vrc4_pkg::CLS_PRG) || (k_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrc4_pkg::ST_IDLE;
			k_q         <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			step_q  <= step_d;
			if (cmd.load_out)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		step_d    = step_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.k     = k_q;
		cmd.last  = is_last;
		unique case (state_q)
			vrc4_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				k_d       = '0;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = vrc4_pkg::ST_EXEC;
				end
			end
			vrc4_pkg::ST_EXEC: begin
				cmd.apply = 1'b1;
				priority case (status.cls)
					vrc4_pkg::CLS_PRG, vrc4_pkg::CLS_CHR: state_d = vrc4_pkg::ST_START;
					vrc4_pkg::CLS_TICK: state_d = vrc4_pkg::ST_PRESC;
					default: state_d = vrc4_pkg::ST_EMIT;
				endcase
			end
			vrc4_pkg::ST_START: begin
				cmd.div_start = 1'b1;
				step_d        = '0;
				state_d       = vrc4_pkg::ST_MOD;
			end
			vrc4_pkg::ST_MOD: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 3'd1;
				if (step_q == 3'd7)
					state_d = vrc4_pkg::ST_EMIT;
			end
			vrc4_pkg::ST_PRESC: begin
				if (status.pres_ge)
					cmd.presc_step = 1'b1;
				else
					state_d = vrc4_pkg::ST_EMIT;
			end
			vrc4_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					if (is_last) begin
						state_d = vrc4_pkg::ST_IDLE;
					end else begin
						k_d     = k_q + 2'd1;
						state_d = vrc4_pkg::ST_START;
					end
				end
			end
			default: state_d = vrc4_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/vrc4_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc4_dp: mapper datapath
// Bank selects, interrupt counter, remainder unit and result register.
// ----------------------------------------------------------------------------
module vrc4_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vrc4_pkg::req_item_t   req_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [10:0]           cfg_wdata,
	input  vrc4_pkg::dp_cmd_t     cmd,
	output vrc4_pkg::dp_status_t  status,
	output vrc4_pkg::res_item_t   res_item
);

	localparam logic [vrc4_pkg::PRESC_W-1:0] PERIOD =
		vrc4_pkg::PRESC_W'(vrc4_pkg::PRESCALE_PERIOD);
	localparam logic [vrc4_pkg::PRESC_W-1:0] STEP =
		vrc4_pkg::PRESC_W'(vrc4_pkg::PRESCALE_STEP);

	vrc4_pkg::req_item_t in_q;
	vrc4_pkg::res_item_t out_q;

	logic [9:0]  prg_count_q;
	logic [10:0] chr_count_q;
	logic        four_screen_q;

	logic [4:0] sel_first_q, sel_second_q;
	logic [7:0] chr_sel_q [vrc4_pkg::CHR_SLOTS];
	logic [1:0] mirror_q;
	logic       swap_q, irq_en_q, irq_ena_q, cycle_q, irq_req_q;
	logic [7:0] reload_q, count_q;
	logic [vrc4_pkg::PRESC_W-1:0] pres_q;

	logic [7:0]  dvd_q;
	logic [10:0] rem_q;

	logic [3:0]  grp;
	logic [1:0]  rsel;
	logic [2:0]  idx;
	logic [9:0]  prg_n;
	logic [8:0]  fixed_bank, last_bank;
	logic [10:0] divisor;
	logic [11:0] trial;
	logic [7:0]  step_count;
	logic        step_fire;
	vrc4_pkg::item_cls_t cls;
	vrc4_pkg::res_item_t res_d;

	assign grp  = in_q.address[15:12];
	assign rsel = {in_q.address[0] | in_q.address[2], in_q.address[1] | in_q.address[3]};
	assign idx  = {2'(grp[1:0] - 2'd3), rsel[1]};

	assign prg_n      = (prg_count_q > 10'(vrc4_pkg::PRG_MAX_BANKS)) ?
		10'(vrc4_pkg::PRG_MAX_BANKS) : prg_count_q;
	assign fixed_bank = (prg_n > 10'd1) ? 9'(prg_n - 10'd2) : 9'd0;
	assign last_bank  = 9'(prg_n - 10'd1);

	assign step_count = (count_q == 8'hFF) ? reload_q : count_q + 8'd1;
	assign step_fire  = (count_q == 8'hFF);

	always_comb begin
		cls = vrc4_pkg::CLS_NONE;
		if (in_q.op == vrc4_pkg::OP_TICK) begin
			if (irq_en_q && !cycle_q)
				cls = vrc4_pkg::CLS_TICK;
		end else if (grp == vrc4_pkg::GRP_PRG0 || grp == vrc4_pkg::GRP_PRG1 ||
				(grp == vrc4_pkg::GRP_MIRSW && rsel[1])) begin
			if (prg_count_q != '0)
				cls = vrc4_pkg::CLS_PRG;
		end else if (grp == vrc4_pkg::GRP_MIRSW) begin
			if (in_q.data != 8'hFF && !four_screen_q)
				cls = vrc4_pkg::CLS_MIR;
		end else if (grp >= vrc4_pkg::GRP_CHR_LO && grp <= vrc4_pkg::GRP_CHR_HI) begin
			if (chr_count_q != '0)
				cls = vrc4_pkg::CLS_CHR;
		end
	end

	assign status.cls     = cls;
	assign status.pres_ge = (pres_q >= PERIOD);

	assign divisor = (cls == vrc4_pkg::CLS_CHR) ? chr_count_q : {1'b0, prg_n};
	assign trial   = {rem_q, dvd_q[7]};

	always_comb begin
		res_d          = '0;
		res_d.irq_line = irq_req_q;
		res_d.last     = cmd.last;
		priority case (cls)
			vrc4_pkg::CLS_PRG: begin
				res_d.event_kind = vrc4_pkg::EV_PRG;
				unique case (cmd.k)
					2'd0: begin
						res_d.slot = 3'd0;
						res_d.bank = swap_q ? fixed_bank : rem_q[8:0];
					end
					2'd1: begin
						res_d.slot = 3'd2;
						res_d.bank = swap_q ? rem_q[8:0] : fixed_bank;
					end
					2'd2: begin
						res_d.slot = 3'd1;
						res_d.bank = rem_q[8:0];
					end
					default: begin
						res_d.slot = 3'd3;
						res_d.bank = last_bank;
					end
				endcase
			end
			vrc4_pkg::CLS_CHR: begin
				res_d.event_kind = vrc4_pkg::EV_CHR;
				res_d.slot       = idx;
				res_d.bank       = rem_q[8:0];
			end
			vrc4_pkg::CLS_MIR: begin
				res_d.event_kind  = vrc4_pkg::EV_MIRROR;
				res_d.mirror_mode = mirror_q;
			end
			default: res_d.event_kind = vrc4_pkg::EV_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= req_item;
		if (cmd.load_out)
			out_q <= res_d;
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cls == vrc4_pkg::CLS_CHR)
				dvd_q <= chr_sel_q[idx];
			else
				dvd_q <= {3'd0, (cmd.k == 2'd2) ? sel_second_q : sel_first_q};
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= 11'(trial - {1'b0, divisor});
			else
				rem_q <= trial[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= 10'd2;
			chr_count_q   <= 11'd8;
			four_screen_q <= 1'b0;
			sel_first_q   <= 5'd0;
			sel_second_q  <= 5'd1;
			for (int i = 0; i < vrc4_pkg::CHR_SLOTS; i++)
				chr_sel_q[i] <= '0;
			mirror_q  <= '0;
			swap_q    <= 1'b0;
			irq_en_q  <= 1'b0;
			irq_ena_q <= 1'b0;
			cycle_q   <= 1'b0;
			irq_req_q <= 1'b0;
			reload_q  <= '0;
			count_q   <= '0;
			pres_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					vrc4_pkg::CFG_PRG_COUNT: prg_count_q   <= cfg_wdata[9:0];
					vrc4_pkg::CFG_CHR_COUNT: chr_count_q   <= cfg_wdata;
					vrc4_pkg::CFG_FOUR_SCR:  four_screen_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.presc_step) begin
				pres_q  <= pres_q - PERIOD;
				count_q <= step_count;
				if (step_fire)
					irq_req_q <= 1'b1;
			end
			if (cmd.apply) begin
				if (in_q.op == vrc4_pkg::OP_TICK) begin
					if (irq_en_q) begin
						if (cycle_q) begin
							count_q <= step_count;
							if (step_fire)
								irq_req_q <= 1'b1;
						end else begin
							pres_q <= pres_q + STEP;
						end
					end
				end else if (grp == vrc4_pkg::GRP_PRG0) begin
					sel_first_q <= in_q.data[4:0];
				end else if (grp == vrc4_pkg::GRP_PRG1) begin
					sel_second_q <= in_q.data[4:0];
				end else if (grp == vrc4_pkg::GRP_MIRSW) begin
					if (!rsel[1])
						mirror_q <= in_q.data[1:0];
					else
						swap_q <= in_q.data[1];
				end else if (grp >= vrc4_pkg::GRP_CHR_LO && grp <= vrc4_pkg::GRP_CHR_HI) begin
					if (chr_count_q != '0) begin
						if (rsel[0])
							chr_sel_q[idx][7:4] <= in_q.data[3:0];
						else
							chr_sel_q[idx][3:0] <= in_q.data[3:0];
					end
				end else if (grp == vrc4_pkg::GRP_IRQ) begin
					irq_req_q <= 1'b0;
					unique case (rsel)
						vrc4_pkg::IRQ_LATCH_LO: reload_q[3:0] <= in_q.data[3:0];
						vrc4_pkg::IRQ_LATCH_HI: reload_q[7:4] <= in_q.data[3:0];
						vrc4_pkg::IRQ_CTRL: begin
							pres_q    <= '0;
							count_q   <= reload_q;
							cycle_q   <= in_q.data[2];
							irq_en_q  <= in_q.data[1];
							irq_ena_q <= in_q.data[0];
						end
						default: irq_en_q <= irq_ena_q;
					endcase
				end
			end
		end
	end

	assign res_item = out_q;

endmodule

// ===== rtl/vrc4_bank_and_irq_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc4_bank_and_irq_mapper_top: bank mapper with interrupt counter
// Decodes CPU register writes into slot loads and runs the IRQ counter.
// ----------------------------------------------------------------------------
// One request at a time. A tick or a write without a slot load goes from the
// update straight to the result (a scanline tick first passes the prescaler
// state, which steps the prescaler while it has reached its period); a
// character write takes one pass and a program write 4 passes through the
// bit-serial remainder unit. A result that waits on res_ready holds back the
// rest of the request. Results leave through a registered output, and the
// four loads of a program write each wait for the output to be free.
module vrc4_bank_and_irq_mapper_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  vrc4_pkg::req_item_t  req_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output vrc4_pkg::res_item_t  res_item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [10:0]          cfg_wdata
);

	vrc4_pkg::dp_cmd_t    cmd;
	vrc4_pkg::dp_status_t status;

	vrc4_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vrc4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.res_item  (res_item)
	);

endmodule
